// ===== hdl/newton_difference_interpolator_defines.svh =====
// Assertion macros for the Newton difference interpolator.
// Included by modules that check their own sequencing; needs clk and arst_n in scope.
`ifndef NEWTON_DIFFERENCE_INTERPOLATOR_DEFINES_SVH
`define NEWTON_DIFFERENCE_INTERPOLATOR_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define NDI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition implies consequence in the following cycle.
`define NDI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ndi_pkg.sv =====
// Shared types, codes and constants of the Newton difference interpolator.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package ndi_pkg;

	localparam int Q_FRAC = 24;
	localparam logic [63:0] SAT_LIM = 64'h3FFF_FFFF_FFFF_FFFF;

	localparam logic [1:0] REG_START_X     = 2'd0;
	localparam logic [1:0] REG_STEP        = 2'd1;
	localparam logic [1:0] REG_POINT_COUNT = 2'd2;
	localparam logic [1:0] REG_ROUND_SCALE = 2'd3;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	localparam logic [1:0] SH_NONE = 2'd0;
	localparam logic [1:0] SH_COEF = 2'd1;
	localparam logic [1:0] SH_OUT  = 2'd2;

	localparam logic [6:0] MUL_LAST = 7'd4;
	localparam logic [6:0] DIV_LAST = 7'd63;

	typedef struct packed {
		logic        op;
		logic [63:0] a;
		logic [63:0] b;
		logic        neg;
		logic [1:0]  sh;
	} unit_cmd_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		logic [63:0] r;
		r = v[63] ? 64'(-v) : 64'(v);
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/newton_difference_interpolator.sv =====
// Newton forward/backward difference interpolator, top level.
// Depends on ndi_pkg and newton_difference_interpolator_defines.svh.
//
// Usage: configuration registers are written on the cfg channel (index 0 start_x,
// 1 step, 2 point_count, 3 round_scale) while the block is idle. Input beats on
// s_axis carry either a sample (tuser 0) or a query (tuser 1). After n samples
// (point_count clamped to 2..MAX_POINTS) the difference table is built, during which
// s_axis_tready is low. A query produces one output beat on m_axis with both Newton
// forms; a load produces none. A query before the table is ready returns zeros with
// the not_ready flag. A query is worked out on the shared radix-2 divider
// (n+1 divisions per form) and the 32x32 multiplier that forms each 64x64 product
// in four passes. One item is worked on at a time. A finished result waits in the
// output register while the receiver stalls; the next beat is still accepted, and a
// further result waits until that register is free. Reset clears the loaded sample
// count, the ready flag, the output valid and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "newton_difference_interpolator_defines.svh"

module newton_difference_interpolator #(
	parameter int MAX_POINTS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [63:0] s_axis_tdata,   // sample_value [31:0], query_x [63:32]
	input  wire  [0:0]  s_axis_tuser,   // req_type [0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [63:0] m_axis_tdata,   // forward_value [31:0], backward_value [63:32]
	output logic [1:0]  m_axis_tuser,   // saturated [0], not_ready [1]
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data
);
	import ndi_pkg::*;

	localparam int IW  = $clog2(MAX_POINTS);
	localparam int PW  = $clog2(MAX_POINTS + 1);
	localparam int DW  = 32 + MAX_POINTS;
	localparam int OSH = FRAC_BITS + Q_FRAC;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_BSTART = 5'd1;
	localparam logic [4:0] S_BSTEP  = 5'd2;
	localparam logic [4:0] S_DX     = 5'd3;
	localparam logic [4:0] S_QGO    = 5'd4;
	localparam logic [4:0] S_QWT    = 5'd5;
	localparam logic [4:0] S_INIT   = 5'd6;
	localparam logic [4:0] S_CMGO   = 5'd7;
	localparam logic [4:0] S_CMWT   = 5'd8;
	localparam logic [4:0] S_CDGO   = 5'd9;
	localparam logic [4:0] S_CDWT   = 5'd10;
	localparam logic [4:0] S_TMGO   = 5'd11;
	localparam logic [4:0] S_TMWT   = 5'd12;
	localparam logic [4:0] S_F1GO   = 5'd13;
	localparam logic [4:0] S_F1WT   = 5'd14;
	localparam logic [4:0] S_F2GO   = 5'd15;
	localparam logic [4:0] S_F2WT   = 5'd16;
	localparam logic [4:0] S_FDGO   = 5'd17;
	localparam logic [4:0] S_FDWT   = 5'd18;
	localparam logic [4:0] S_OUT    = 5'd19;

	logic [4:0] state_q;

	logic signed [31:0] start_x_q;
	logic [30:0]        step_q;
	logic [4:0]         point_count_q;
	logic [15:0]        round_scale_q;

	logic [PW-1:0] loaded_q;
	logic          ready_q;
	logic [PW-1:0] k_q;
	logic [PW-1:0] j_q;
	logic [PW-1:0] i_q;
	logic          dir_q;

	logic signed [DW-1:0] vec_q [MAX_POINTS];
	logic signed [DW-1:0] fwd_q [MAX_POINTS];
	logic signed [DW-1:0] bwd_q [MAX_POINTS];
	logic signed [DW-1:0] held_q;

	logic signed [31:0] x_q;
	logic signed [63:0] dx_q;
	logic signed [63:0] q_q;
	logic signed [63:0] c_q;
	logic signed [63:0] acc_q;
	logic               sat_q;
	logic               nr_q;
	logic [31:0]        fres_q;
	logic [31:0]        bres_q;

	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic [1:0]  out_user_q;

	logic         u_run_q;
	logic         u_done_q;
	logic [6:0]   u_cnt_q;
	logic         u_op_q;
	logic [63:0]  u_a_q;
	logic [63:0]  u_b_q;
	logic         u_neg_q;
	logic [1:0]   u_sh_q;
	logic [127:0] u_p_q;
	logic [31:0]  u_rem_q;

	logic [6:0]    pc_w;
	logic [6:0]    n7_w;
	logic [PW-1:0] n_w;
	logic [PW-1:0] nm1_w;
	logic [30:0]   h_w;
	logic [15:0]   rs_w;
	logic          in_acc;
	logic          out_free;

	logic          restart_w;
	logic [PW-1:0] ld_idx_w;
	logic [PW-1:0] ld_next_w;

	logic [PW-1:0]        len_w;
	logic [PW-1:0]        jn_w;
	logic [PW-1:0]        km1_w;
	logic [IW-1:0]        rd_idx_w;
	logic signed [DW-1:0] rd_val_w;

	logic [PW+30:0]     xoff_w;
	logic [PW-1:0]      im1_w;
	logic [PW-1:0]      inx_w;
	logic signed [63:0] off_w;
	logic signed [63:0] f_w;
	logic signed [63:0] d_w;

	unit_cmd_t cmd;
	logic      launch;

	logic [31:0]        a_half_w;
	logic [31:0]        b_half_w;
	logic [63:0]        pp_w;
	logic [127:0]       pp_sh_w;
	logic [127:0]       rnd_w;
	logic [127:0]       rsum_w;
	logic [127:0]       rshift_w;
	logic [32:0]        rem_n_w;
	logic               ge_w;
	logic [32:0]        rem_sub_w;
	logic [31:0]        rem_next_w;
	logic               mul_sat_w;
	logic [63:0]        mul_mag_w;
	logic signed [63:0] mul_res_w;
	logic signed [63:0] div_res_w;
	logic signed [63:0] sum_w;
	logic               add_hi_w;
	logic               add_lo_w;
	logic signed [63:0] acc_next_w;
	logic               fd_over_w;
	logic [31:0]        fd_val_w;

	assign pc_w  = 7'(point_count_q);
	assign n7_w  = (pc_w < 7'd2) ? 7'd2 : ((pc_w > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : pc_w);
	assign n_w   = n7_w[PW-1:0];
	assign nm1_w = n_w - PW'(1);
	assign h_w   = (step_q == 31'd0) ? 31'd1 : step_q;
	assign rs_w  = (round_scale_q == 16'd0) ? 16'd1 : round_scale_q;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	assign restart_w = ready_q || (loaded_q >= n_w);
	assign ld_idx_w  = restart_w ? '0 : loaded_q;
	assign ld_next_w = ld_idx_w + PW'(1);

	assign len_w    = n_w - k_q;
	assign jn_w     = j_q + PW'(1);
	assign km1_w    = k_q - PW'(1);
	assign rd_idx_w = (state_q == S_BSTART) ? '0 : jn_w[IW-1:0];
	assign rd_val_w = vec_q[rd_idx_w];

	assign xoff_w = {{PW{1'b0}}, h_w} * {{31{1'b0}}, nm1_w};
	assign im1_w  = i_q - PW'(1);
	assign inx_w  = i_q + PW'(1);
	assign off_w  = $signed({{(64 - PW){1'b0}}, im1_w}) <<< Q_FRAC;
	assign f_w    = dir_q ? (q_q + off_w) : (q_q - off_w);
	assign d_w    = dir_q ? 64'(bwd_q[i_q[IW-1:0]]) : 64'(fwd_q[i_q[IW-1:0]]);

	always_comb begin
		cmd    = '0;
		launch = 1'b0;
		unique case (state_q)
			S_QGO: begin
				launch  = 1'b1;
				cmd.op  = OP_DIV;
				cmd.a   = (mag64(dx_q) << (Q_FRAC + 1)) + 64'(h_w);
				cmd.b   = 64'({h_w, 1'b0});
				cmd.neg = dx_q[63];
			end
			S_CMGO: begin
				launch  = 1'b1;
				cmd.op  = OP_MUL;
				cmd.a   = mag64(c_q);
				cmd.b   = mag64(f_w);
				cmd.neg = c_q[63] ^ f_w[63];
				cmd.sh  = SH_COEF;
			end
			S_CDGO: begin
				launch  = 1'b1;
				cmd.op  = OP_DIV;
				cmd.a   = (mag64(c_q) << 1) + 64'(i_q);
				cmd.b   = 64'({i_q, 1'b0});
				cmd.neg = c_q[63];
			end
			S_TMGO: begin
				launch  = 1'b1;
				cmd.op  = OP_MUL;
				cmd.a   = mag64(d_w);
				cmd.b   = mag64(c_q);
				cmd.neg = d_w[63] ^ c_q[63];
				cmd.sh  = SH_NONE;
			end
			S_F1GO: begin
				launch  = 1'b1;
				cmd.op  = OP_MUL;
				cmd.a   = mag64(acc_q);
				cmd.b   = 64'(rs_w);
				cmd.neg = acc_q[63];
				cmd.sh  = SH_OUT;
			end
			S_F2GO: begin
				launch  = 1'b1;
				cmd.op  = OP_MUL;
				cmd.a   = mag64(c_q);
				cmd.b   = 64'(1) << FRAC_BITS;
				cmd.neg = c_q[63];
				cmd.sh  = SH_NONE;
			end
			S_FDGO: begin
				launch  = 1'b1;
				cmd.op  = OP_DIV;
				cmd.a   = (mag64(c_q) << 1) + 64'(rs_w);
				cmd.b   = 64'({rs_w, 1'b0});
				cmd.neg = c_q[63];
			end
			default: begin
			end
		endcase
	end

	// Shared unit: a 64x64 product from four 32x32 passes plus an optional rounding shift,
	// or a restoring divide producing one quotient bit per cycle.
	assign a_half_w = u_cnt_q[1] ? u_a_q[63:32] : u_a_q[31:0];
	assign b_half_w = u_cnt_q[0] ? u_b_q[63:32] : u_b_q[31:0];
	assign pp_w     = a_half_w * b_half_w;

	always_comb begin
		case (u_cnt_q[1:0]) inside
			2'd0:       pp_sh_w = 128'(pp_w);
			2'd1, 2'd2: pp_sh_w = 128'(pp_w) << 32;
			default:    pp_sh_w = 128'(pp_w) << 64;
		endcase
	end

	always_comb begin
		case (u_sh_q)
			SH_COEF: begin
				rnd_w    = 128'(1) << (Q_FRAC - 1);
				rsum_w   = u_p_q + rnd_w;
				rshift_w = rsum_w >> Q_FRAC;
			end
			SH_OUT: begin
				rnd_w    = 128'(1) << (OSH - 1);
				rsum_w   = u_p_q + rnd_w;
				rshift_w = rsum_w >> OSH;
			end
			default: begin
				rnd_w    = '0;
				rsum_w   = u_p_q;
				rshift_w = rsum_w;
			end
		endcase
	end

	assign rem_n_w    = {u_rem_q, u_a_q[63]};
	assign ge_w       = rem_n_w >= {1'b0, u_b_q[31:0]};
	assign rem_sub_w  = rem_n_w - {1'b0, u_b_q[31:0]};
	assign rem_next_w = ge_w ? rem_sub_w[31:0] : rem_n_w[31:0];

	assign mul_sat_w = (|u_p_q[127:64]) || (u_p_q[63:0] > SAT_LIM);
	assign mul_mag_w = mul_sat_w ? SAT_LIM : u_p_q[63:0];
	assign mul_res_w = u_neg_q ? -$signed(mul_mag_w) : $signed(mul_mag_w);
	assign div_res_w = u_neg_q ? -$signed(u_a_q) : $signed(u_a_q);

	assign sum_w      = acc_q + mul_res_w;
	assign add_hi_w   = sum_w > $signed(SAT_LIM);
	assign add_lo_w   = sum_w < -$signed(SAT_LIM);
	assign acc_next_w = add_hi_w ? $signed(SAT_LIM) : (add_lo_w ? -$signed(SAT_LIM) : sum_w);

	assign fd_over_w = u_neg_q ? (u_a_q > 64'h8000_0000) : (u_a_q > 64'h7FFF_FFFF);
	assign fd_val_w  = u_neg_q ? (fd_over_w ? 32'h8000_0000 : 32'd0 - u_a_q[31:0])
	                           : (fd_over_w ? 32'h7FFF_FFFF : u_a_q[31:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_run_q  <= 1'b0;
			u_done_q <= 1'b0;
			u_cnt_q  <= '0;
		end else begin
			u_done_q <= 1'b0;
			if (launch) begin
				u_run_q <= 1'b1;
				u_cnt_q <= '0;
			end else if (u_run_q) begin
				u_cnt_q <= u_cnt_q + 7'd1;
				if ((u_op_q == OP_MUL && u_cnt_q == MUL_LAST) ||
				    (u_op_q == OP_DIV && u_cnt_q == DIV_LAST)) begin
					u_run_q  <= 1'b0;
					u_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			u_op_q  <= cmd.op;
			u_a_q   <= cmd.a;
			u_b_q   <= cmd.b;
			u_neg_q <= cmd.neg;
			u_sh_q  <= cmd.sh;
			u_p_q   <= '0;
			u_rem_q <= '0;
		end else if (u_run_q) begin
			if (u_op_q == OP_MUL) begin
				if (u_cnt_q == MUL_LAST) begin
					u_p_q <= rshift_w;
				end else begin
					u_p_q <= u_p_q + pp_sh_w;
				end
			end else begin
				u_a_q   <= {u_a_q[62:0], ge_w};
				u_rem_q <= rem_next_w;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			loaded_q      <= '0;
			ready_q       <= 1'b0;
			k_q           <= '0;
			j_q           <= '0;
			i_q           <= '0;
			dir_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			start_x_q     <= 32'sd0;
			step_q        <= 31'd65536;
			point_count_q <= 5'd8;
			round_scale_q <= 16'd10000;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser[0] == REQ_LOAD) begin
							loaded_q <= ld_next_w;
							ready_q  <= 1'b0;
							if (ld_next_w == n_w) begin
								k_q     <= PW'(1);
								state_q <= S_BSTART;
							end
						end else if (!ready_q) begin
							state_q <= S_OUT;
						end else begin
							dir_q   <= 1'b0;
							state_q <= S_DX;
						end
					end
				end
				S_BSTART: begin
					if (len_w == '0) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						j_q     <= '0;
						state_q <= S_BSTEP;
					end
				end
				S_BSTEP: begin
					if (jn_w == len_w) begin
						k_q     <= k_q + PW'(1);
						state_q <= S_BSTART;
					end else begin
						j_q <= jn_w;
					end
				end
				S_DX:   state_q <= S_QGO;
				S_QGO:  state_q <= S_QWT;
				S_QWT:  if (u_done_q) state_q <= S_INIT;
				S_INIT: begin
					i_q     <= PW'(1);
					state_q <= S_CMGO;
				end
				S_CMGO: state_q <= S_CMWT;
				S_CMWT: if (u_done_q) state_q <= S_CDGO;
				S_CDGO: state_q <= S_CDWT;
				S_CDWT: if (u_done_q) state_q <= S_TMGO;
				S_TMGO: state_q <= S_TMWT;
				S_TMWT: begin
					if (u_done_q) begin
						if (inx_w == n_w) begin
							state_q <= S_F1GO;
						end else begin
							i_q     <= inx_w;
							state_q <= S_CMGO;
						end
					end
				end
				S_F1GO: state_q <= S_F1WT;
				S_F1WT: if (u_done_q) state_q <= S_F2GO;
				S_F2GO: state_q <= S_F2WT;
				S_F2WT: if (u_done_q) state_q <= S_FDGO;
				S_FDGO: state_q <= S_FDWT;
				S_FDWT: begin
					if (u_done_q) begin
						if (!dir_q) begin
							dir_q   <= 1'b1;
							state_q <= S_DX;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_START_X:     start_x_q <= cfg_data;
					REG_STEP:        step_q <= cfg_data[30:0];
					REG_POINT_COUNT: begin
						point_count_q <= cfg_data[4:0];
						loaded_q      <= '0;
						ready_q       <= 1'b0;
					end
					REG_ROUND_SCALE: round_scale_q <= cfg_data[15:0];
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (s_axis_tuser[0] == REQ_LOAD) begin
						vec_q[ld_idx_w[IW-1:0]] <= DW'($signed(s_axis_tdata[31:0]));
					end else begin
						x_q    <= s_axis_tdata[63:32];
						sat_q  <= 1'b0;
						nr_q   <= !ready_q;
						fres_q <= '0;
						bres_q <= '0;
					end
				end
			end
			S_BSTART: begin
				held_q              <= rd_val_w;
				fwd_q[km1_w[IW-1:0]] <= rd_val_w;
				if (len_w == '0) begin
					bwd_q[km1_w[IW-1:0]] <= rd_val_w;
				end
			end
			S_BSTEP: begin
				vec_q[j_q[IW-1:0]] <= rd_val_w - held_q;
				held_q             <= rd_val_w;
				if (jn_w == len_w) begin
					bwd_q[km1_w[IW-1:0]] <= rd_val_w;
				end
			end
			S_DX: begin
				dx_q <= dir_q ? (64'(x_q) - 64'(start_x_q) - 64'(xoff_w))
				              : (64'(x_q) - 64'(start_x_q));
			end
			S_QWT: if (u_done_q) q_q <= div_res_w;
			S_INIT: begin
				acc_q <= (dir_q ? 64'(bwd_q[0]) : 64'(fwd_q[0])) <<< Q_FRAC;
				c_q   <= 64'(1) << Q_FRAC;
			end
			S_CMWT: begin
				if (u_done_q) begin
					c_q   <= mul_res_w;
					sat_q <= sat_q | mul_sat_w;
				end
			end
			S_CDWT: if (u_done_q) c_q <= div_res_w;
			S_TMWT: begin
				if (u_done_q) begin
					acc_q <= acc_next_w;
					sat_q <= sat_q | mul_sat_w | add_hi_w | add_lo_w;
				end
			end
			S_F1WT, S_F2WT: begin
				if (u_done_q) begin
					c_q   <= mul_res_w;
					sat_q <= sat_q | mul_sat_w;
				end
			end
			S_FDWT: begin
				if (u_done_q) begin
					if (!dir_q) begin
						fres_q <= fd_val_w;
					end else begin
						bres_q <= fd_val_w;
					end
					sat_q <= sat_q | fd_over_w;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_data_q <= {bres_q, fres_q};
					out_user_q <= {nr_q, sat_q};
				end
			end
			default: begin
			end
		endcase
	end

	`NDI_ASSERT_NOW(a_launch_idle, launch, !u_run_q, "shared unit launched while busy")
	`NDI_ASSERT_NOW(a_done_in_wait, u_done_q, (state_q == S_QWT || state_q == S_CMWT || state_q == S_CDWT || state_q == S_TMWT || state_q == S_F1WT || state_q == S_F2WT || state_q == S_FDWT), "unit result arrived outside a wait state")
	`NDI_ASSERT_NOW(a_ready_count, ready_q, loaded_q == n_w, "table ready without a full sample set")
	`NDI_ASSERT_NOW(a_term_index, (state_q == S_CMGO || state_q == S_TMGO), (i_q != '0 && i_q < n_w), "term index out of range")
	`NDI_ASSERT_NEXT(a_query_start, (in_acc && s_axis_tuser[0] == REQ_EVAL), (state_q == S_OUT || state_q == S_DX), "query did not start")

endmodule

`default_nettype wire

// ===== tb/newton_difference_interpolator_test.sv =====
// Self-checking testbench for the Newton difference interpolator top level.
// Drives samples and queries over the stream ports and checks every result against a
// built-in predictor. Depends on ndi_pkg and the newton_difference_interpolator RTL.
`timescale 1ns / 1ps

module newton_difference_interpolator_test;
	import ndi_pkg::*;

	localparam int PTS = 16;
	localparam logic [63:0] CLIP = 64'h3FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [31:0] fwd;
		logic [31:0] bwd;
		logic        sat;
		logic        nrdy;
	} interp_t;

	typedef struct {
		logic        req;
		logic [31:0] sample;
		logic [31:0] qx;
		bit          typed;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	newton_difference_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	longint diff_tab[PTS][PTS];
	int unsigned samples_held;
	bit table_built;
	logic [31:0] m_start_x;
	logic [30:0] m_step;
	logic [4:0] m_count;
	logic [15:0] m_scale;
	bit clip_seen;

	interp_t pending_q[$];
	bit failed;
	int send_idle;
	int recv_stall;
	int recv_hold;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic int points();
		if (m_count < 2)
			return 2;
		if (m_count > PTS)
			return PTS;
		return m_count;
	endfunction

	function automatic logic [63:0] spacing();
		return (m_step == 0) ? 64'd1 : 64'(m_step);
	endfunction

	function automatic logic [63:0] umag(longint a);
		return (a < 0) ? 64'(-a) : 64'(a);
	endfunction

	function automatic longint signed_of(logic [63:0] m, bit neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint mul_round(longint a, longint b, int sh);
		logic [127:0] p;
		logic [63:0] r;
		p = 128'(umag(a)) * 128'(umag(b));
		if (sh > 0)
			p = (p + (128'(1) << (sh - 1))) >> sh;
		if (p > 128'(CLIP)) begin
			clip_seen = 1'b1;
			r = CLIP;
		end else begin
			r = p[63:0];
		end
		return signed_of(r, (a < 0) != (b < 0));
	endfunction

	function automatic longint div_round(longint a, logic [63:0] d);
		return signed_of((2 * umag(a) + d) / (2 * d), a < 0);
	endfunction

	function automatic longint add_clip(longint a, longint b);
		longint s;
		s = a + b;
		if (s > longint'(CLIP)) begin
			clip_seen = 1'b1;
			s = longint'(CLIP);
		end
		if (s < -longint'(CLIP)) begin
			clip_seen = 1'b1;
			s = -longint'(CLIP);
		end
		return s;
	endfunction

	function automatic longint newton_sum(longint dx, bit backward, int n);
		logic [63:0] h;
		longint q, acc, c, off, f;
		int base, row;
		h = spacing();
		q = signed_of(((umag(dx) << Q_FRAC) * 2 + h) / (2 * h), dx < 0);
		base = backward ? n - 1 : 0;
		acc = diff_tab[base][0] * (longint'(1) << Q_FRAC);
		c = longint'(1) << Q_FRAC;
		for (int i = 1; i < n; i++) begin
			off = longint'(i - 1) << Q_FRAC;
			f = backward ? q + off : q - off;
			row = backward ? n - 1 - i : 0;
			c = mul_round(c, f, Q_FRAC);
			c = div_round(c, 64'(i));
			acc = add_clip(acc, mul_round(diff_tab[row][i], c, 0));
		end
		return acc;
	endfunction

	function automatic logic [31:0] to_q16(longint acc);
		logic [63:0] rs, r;
		longint m, num;
		rs = (m_scale == 0) ? 64'd1 : 64'(m_scale);
		m = mul_round(acc, longint'(rs), 16 + Q_FRAC);
		num = mul_round(m, longint'(1) << 16, 0);
		r = (2 * umag(num) + rs) / (2 * rs);
		if (num < 0) begin
			if (r > 64'h8000_0000) begin
				r = 64'h8000_0000;
				clip_seen = 1'b1;
			end
			return 32'(-longint'(r));
		end
		if (r > 64'h7FFF_FFFF) begin
			r = 64'h7FFF_FFFF;
			clip_seen = 1'b1;
		end
		return r[31:0];
	endfunction

	task automatic interp_reset();
		for (int j = 0; j < PTS; j++)
			for (int k = 0; k < PTS; k++)
				diff_tab[j][k] = 0;
		samples_held = 0;
		table_built = 1'b0;
		m_start_x = 32'd0;
		m_step = 31'd65536;
		m_count = 5'd8;
		m_scale = 16'd10000;
	endtask

	task automatic interp_accept(logic req, logic [31:0] sample, logic [31:0] qx);
		int n;
		longint x, x0, xl;
		interp_t r;
		n = points();
		if (req == REQ_LOAD) begin
			if (table_built || samples_held >= n) begin
				samples_held = 0;
				table_built = 1'b0;
			end
			diff_tab[samples_held][0] = longint'($signed(sample));
			samples_held++;
			if (samples_held == n) begin
				for (int k = 1; k < n; k++)
					for (int j = 0; j + k < n; j++)
						diff_tab[j][k] = diff_tab[j + 1][k - 1] - diff_tab[j][k - 1];
				table_built = 1'b1;
			end
			return;
		end
		r = '{32'd0, 32'd0, 1'b0, 1'b0};
		if (!table_built) begin
			r.nrdy = 1'b1;
		end else begin
			clip_seen = 1'b0;
			x = longint'($signed(qx));
			x0 = longint'($signed(m_start_x));
			xl = x0 + longint'(n - 1) * longint'(spacing());
			r.fwd = to_q16(newton_sum(x - x0, 1'b0, n));
			r.bwd = to_q16(newton_sum(x - xl, 1'b1, n));
			r.sat = clip_seen;
		end
		pending_q.push_back(r);
	endtask

	task automatic send_beat(logic req, logic [31:0] sample, logic [31:0] qx, bit typed);
		bit rdy;
		if ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {qx, sample};
		s_axis_tuser <= req;
		do begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
		end while (!rdy);
		if (typed)
			pending_q.push_back('{32'd0, 32'd0, 1'b0, 1'b1});
		else
			interp_accept(req, sample, qx);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		bit rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		case (idx)
			REG_START_X: m_start_x = value;
			REG_STEP: m_step = value[30:0];
			REG_POINT_COUNT: begin
				m_count = value[4:0];
				samples_held = 0;
				table_built = 1'b0;
			end
			default: m_scale = value[15:0];
		endcase
	endtask

	task automatic drain();
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [31:0] any_sample();
		if ($urandom_range(99) < 60)
			return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
		return $urandom;
	endfunction

	function automatic logic [31:0] any_query();
		longint off;
		if ($urandom_range(99) < 75) begin
			off = longint'($urandom_range((points() + 1) * 256)) - 256;
			return 32'(longint'($signed(m_start_x)) + off * longint'(spacing()) / 256);
		end
		return $urandom;
	endfunction

	task automatic run_items(int budget);
		int done, n, pick, cnt;
		done = 0;
		while (done < budget) begin
			n = points();
			pick = $urandom_range(99);
			if (pick < 80) begin
				for (int k = 0; k < n; k++)
					send_beat(REQ_LOAD, any_sample(), $urandom, 1'b0);
				cnt = $urandom_range(1, 4);
				for (int k = cnt; k > 0; k--)
					send_beat(REQ_EVAL, $urandom, any_query(), 1'b0);
				done += n + cnt;
			end else if (pick < 90) begin
				send_beat(REQ_EVAL, $urandom, any_query(), 1'b0);
				done++;
			end else begin
				cnt = $urandom_range(1, n - 1);
				for (int k = cnt; k > 0; k--)
					send_beat(REQ_LOAD, any_sample(), $urandom, 1'b0);
				done += cnt;
			end
		end
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin
		bit fire;
		logic [63:0] data;
		logic [1:0] user;
		interp_t want;
		forever begin
			@(negedge clk);
			fire = m_axis_tvalid && m_axis_tready;
			data = m_axis_tdata;
			user = m_axis_tuser;
			@(posedge clk);
			if (fire) begin
				if (pending_q.size() == 0) begin
					$error("result beat with nothing expected: %h %b", data, user);
					failed = 1'b1;
				end else begin
					want = pending_q.pop_front();
					if (data[31:0] !== want.fwd) begin
						$error("forward_value expected %h got %h", want.fwd, data[31:0]);
						failed = 1'b1;
					end
					if (data[63:32] !== want.bwd) begin
						$error("backward_value expected %h got %h", want.bwd, data[63:32]);
						failed = 1'b1;
					end
					if (user[0] !== want.sat) begin
						$error("saturated expected %b got %b", want.sat, user[0]);
						failed = 1'b1;
					end
					if (user[1] !== want.nrdy) begin
						$error("not_ready expected %b got %b", want.nrdy, user[1]);
						failed = 1'b1;
					end
				end
			end
			if (recv_hold > 0) begin
				recv_hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	initial begin
		stim_row_t rows[$];
		logic [31:0] sx, st, pc, rs;
		interp_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_START_X, 32'd0);
		write_reg(REG_STEP, 32'd65536);
		write_reg(REG_POINT_COUNT, 32'd2);
		write_reg(REG_ROUND_SCALE, 32'd1);
		cfg_valid <= 1'b0;

		rows = '{
			'{REQ_EVAL, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1},
			'{REQ_LOAD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0},
			'{REQ_EVAL, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1},
			'{REQ_LOAD, 32'h8000_0000, 32'h0000_0000, 1'b0},
			'{REQ_EVAL, 32'h0000_0000, 32'h0000_0000, 1'b0},
			'{REQ_EVAL, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0},
			'{REQ_EVAL, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0},
			'{REQ_EVAL, 32'h0000_0000, 32'h0000_8000, 1'b0},
			'{REQ_LOAD, 32'h0001_0000, 32'h0000_0000, 1'b0},
			'{REQ_EVAL, 32'h0000_0000, 32'h0000_0000, 1'b1},
			'{REQ_LOAD, 32'h0002_0000, 32'h0000_0000, 1'b0},
			'{REQ_EVAL, 32'h0000_0000, 32'h0001_8000, 1'b0},
			'{REQ_EVAL, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0},
			'{REQ_LOAD, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
			'{REQ_LOAD, 32'h0000_0000, 32'h0000_0000, 1'b0},
			'{REQ_EVAL, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0},
			'{REQ_EVAL, 32'h0000_0000, 32'h8000_0000, 1'b0}
		};
		foreach (rows[i])
			send_beat(rows[i].req, rows[i].sample, rows[i].qx, rows[i].typed);
		s_axis_tvalid <= 1'b0;

		for (int phase = 0; phase < 12; phase++) begin
			drain();
			sx = ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(1 << 22)) - (1 << 21));
			st = $urandom_range(1 << 12, 1 << 18);
			pc = $urandom_range(2, 5);
			rs = $urandom_range(1, 65535);
			case (phase)
				0: begin sx = 32'h8000_0000; st = 32'd0; pc = 32'd0; rs = 32'd0; end
				1: begin sx = 32'h7FFF_FFFF; st = 32'h7FFF_FFFF; pc = 32'd1; rs = 32'd65535; end
				2: begin st = 32'd1; pc = 32'd16; rs = 32'd10000; end
				3: begin pc = 32'd31; rs = 32'd1; end
				4: begin st = 32'hFFFF_FFFF; pc = 32'd17; end
				5: pc = 32'd3;
				default: ;
			endcase
			write_reg(REG_START_X, sx);
			write_reg(REG_STEP, st);
			write_reg(REG_POINT_COUNT, pc);
			write_reg(REG_ROUND_SCALE, rs);
			cfg_valid <= 1'b0;
			send_idle = (phase % 4 == 1) ? 81 : (phase % 4 == 3) ? 21 : 0;
			recv_stall = (phase % 4 == 2) ? 81 : (phase % 4 == 3) ? 21 : 0;
			if (phase == 5) begin
				@(negedge clk);
				recv_hold = 6000;
				@(posedge clk);
				for (int k = 0; k < 3; k++)
					send_beat(REQ_LOAD, any_sample(), $urandom, 1'b0);
				for (int k = 0; k < 6; k++)
					send_beat(REQ_EVAL, $urandom, any_query(), 1'b0);
				s_axis_tvalid <= 1'b0;
				while (pending_q.size() != 0)
					@(posedge clk);
			end
			run_items((phase >= 2 && phase <= 4) ? 60 : 135);
		end

		send_idle = 0;
		recv_stall = 0;
		drain();
		repeat (3000) @(posedge clk);
		if (!failed)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
